### rtl/cia_timer_interrupt_unit_core_defines.svh
// Assertion macros shared by the CIA timer and interrupt unit RTL.
`ifndef CIA_TIMER_INTERRUPT_UNIT_CORE_DEFINES_SVH
`define CIA_TIMER_INTERRUPT_UNIT_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Property checked at every clock edge outside reset.
`define CIATU_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("ciatu assertion failed");
// Condition that must hold in the cycle after a trigger.
`define CIATU_ASSERT_NEXT(lbl, trig, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |=> (prop)) \
      else $error("ciatu assertion failed");
`else
`define CIATU_ASSERT(lbl, prop)
`define CIATU_ASSERT_NEXT(lbl, trig, prop)
`endif

`endif

### rtl/ciatu_pkg.sv
// Types and constants shared by the CIA timer and interrupt unit modules.
package ciatu_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [3:0] REG_ICR   = 4'hD;
   localparam logic [3:0] REG_CTL_A = 4'hE;
   localparam logic [3:0] REG_CTL_B = 4'hF;

   localparam int CTL_START_BIT   = 0;
   localparam int CTL_ONESHOT_BIT = 3;
   localparam int CTL_FORCE_BIT   = 4;
   localparam int ICR_SET_BIT     = 7;

   localparam logic [7:0] READ_IDLE = 8'hFF;

   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_TICK  = 2'd2,
      OP_NOP   = 2'd3
   } op_kind_type;

   typedef enum logic [2:0] {
      RC_PLAIN,
      RC_TIMER_LO,
      RC_TIMER_HI,
      RC_ICR,
      RC_CTL
   } reg_class_type;

   typedef struct packed {
      logic [1:0] command;
      logic [3:0] reg_index;
      logic [7:0] write_data;
      logic [3:0] tick_cycles;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       irq;
   } rsp_payload_type;

   typedef struct packed {
      op_kind_type   kind;
      reg_class_type reg_class;
      logic          timer_sel;
      logic [3:0]    reg_index;
      logic [7:0]    data;
      logic [3:0]    cycles;
   } op_type;

endpackage

### rtl/ciatu_front.sv
// Front end: accepts requests, decodes the register class and queues the ops.
module ciatu_front
   import ciatu_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   output logic            full,
   input  req_payload_type req_payload,
   output logic            op_valid,
   output op_type          op,
   input  logic            op_pop
);

   op_type                 queue_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   op_type                 decoded;
   logic                   accept;
   logic                   take;

   always_comb begin
      decoded.kind      = op_kind_type'(req_payload.command);
      decoded.reg_index = req_payload.reg_index;
      decoded.data      = req_payload.write_data;
      decoded.cycles    = req_payload.tick_cycles;
      case (req_payload.reg_index) inside
         4'h4, 4'h6:           decoded.reg_class = RC_TIMER_LO;
         4'h5, 4'h7:           decoded.reg_class = RC_TIMER_HI;
         REG_ICR:              decoded.reg_class = RC_ICR;
         REG_CTL_A, REG_CTL_B: decoded.reg_class = RC_CTL;
         default:              decoded.reg_class = RC_PLAIN;
      endcase
      // timer registers: bit 1 picks A/B; control registers: bit 0
      decoded.timer_sel = (decoded.reg_class == RC_CTL) ? req_payload.reg_index[0]
                                                        : req_payload.reg_index[1];
   end

   assign full     = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign accept   = push && !full;
   assign op_valid = (count_ff != '0);
   assign op       = queue_ff[rd_ptr_ff];
   assign take     = op_pop && op_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (accept) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (take) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (accept && !take) begin
         count_in = count_ff + 1'b1;
      end else if (take && !accept) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         queue_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

### rtl/ciatu_back.sv
// Back end: register file, both interval timers, interrupt unit, result queue.
`include "cia_timer_interrupt_unit_core_defines.svh"
module ciatu_back
   import ciatu_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            op_valid,
   input  op_type          op,
   output logic            op_pop,
   output logic            empty,
   input  logic            pop,
   output rsp_payload_type rsp_payload
);

   typedef struct packed {
      logic [15:0] count;
      logic [7:0]  ctl;
      logic        under;
   } timer_step_type;

   function automatic timer_step_type timer_advance(input logic [15:0] latch,
                                                    input logic [15:0] count,
                                                    input logic [7:0]  ctl,
                                                    input logic [3:0]  cyc);
      timer_step_type s;
      logic [15:0]    base;
      logic [15:0]    now;
      logic [7:0]     c;
      c       = ctl;
      base    = count;
      s.under = 1'b0;
      if (c[CTL_FORCE_BIT]) begin
         base             = latch;
         c[CTL_FORCE_BIT] = 1'b0;
      end
      now = base;
      if (c[CTL_START_BIT]) begin
         now = base - {12'd0, cyc};
         if (latch == '0) begin
            now = '0;
         end
         if (now > base) begin
            s.under = 1'b1;
            if (!c[CTL_ONESHOT_BIT]) begin
               // latch - (0xFFFF - now), mod 2^16
               now = latch + now + 16'd1;
            end else begin
               c[CTL_START_BIT] = 1'b0;
               now              = '0;
            end
         end
      end
      s.count = now;
      s.ctl   = c;
      return s;
   endfunction

   logic [7:0]  plain_ff [16];
   logic [15:0] latch_ff [2], latch_in [2];
   logic [15:0] count_ff [2], count_in [2];
   logic [7:0]  ctl_ff   [2], ctl_in   [2];
   logic [6:0]  mask_ff, mask_in;
   logic [7:0]  flags_ff, flags_in;
   logic        plain_we;
   logic [7:0]  read_data;
   timer_step_type step [2];

   rsp_payload_type        res_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] res_cnt_ff, res_cnt_in;
   logic                   res_full;
   logic                   res_take;
   rsp_payload_type        result;

   assign res_full = (res_cnt_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign empty    = (res_cnt_ff == '0);
   assign res_take = pop && !empty;
   assign op_pop   = op_valid && (!res_full || res_take);
   assign rsp_payload = res_ff[rd_ptr_ff];

   always_comb begin
      for (int t = 0; t < 2; t++) begin
         step[t] = timer_advance(latch_ff[t], count_ff[t], ctl_ff[t], op.cycles);
      end
   end

   always_comb begin
      latch_in  = latch_ff;
      count_in  = count_ff;
      ctl_in    = ctl_ff;
      mask_in   = mask_ff;
      flags_in  = flags_ff;
      plain_we  = 1'b0;
      read_data = READ_IDLE;
      if (op_pop) begin
         case (op.kind)
            OP_READ: begin
               case (op.reg_class)
                  RC_TIMER_LO: read_data = count_ff[op.timer_sel][7:0];
                  RC_TIMER_HI: read_data = count_ff[op.timer_sel][15:8];
                  RC_ICR: begin
                     read_data = flags_ff;
                     flags_in  = '0;
                  end
                  RC_CTL:      read_data = ctl_ff[op.timer_sel];
                  default:     read_data = plain_ff[op.reg_index];
               endcase
            end
            OP_WRITE: begin
               case (op.reg_class)
                  RC_TIMER_LO: latch_in[op.timer_sel][7:0]  = op.data;
                  RC_TIMER_HI: latch_in[op.timer_sel][15:8] = op.data;
                  RC_ICR: begin
                     if (op.data[ICR_SET_BIT]) begin
                        mask_in = mask_ff | op.data[6:0];
                     end else begin
                        mask_in = mask_ff & ~op.data[6:0];
                     end
                     flags_in = flags_ff & ~op.data;
                  end
                  RC_CTL:      ctl_in[op.timer_sel] = op.data;
                  default:     plain_we = 1'b1;
               endcase
            end
            OP_TICK: begin
               for (int t = 0; t < 2; t++) begin
                  count_in[t] = step[t].count;
                  ctl_in[t]   = step[t].ctl;
               end
               flags_in = flags_ff | {6'd0, step[1].under & mask_ff[1],
                                      step[0].under & mask_ff[0]};
            end
            default: ;
         endcase
      end
      result.read_data = read_data;
      result.irq       = |(flags_in[6:0] & mask_in);
   end

   always_comb begin
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      res_cnt_in = res_cnt_ff;
      if (op_pop) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (res_take) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (op_pop && !res_take) begin
         res_cnt_in = res_cnt_ff + 1'b1;
      end else if (res_take && !op_pop) begin
         res_cnt_in = res_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) begin
            plain_ff[i] <= '0;
         end
         for (int t = 0; t < 2; t++) begin
            latch_ff[t] <= '0;
            count_ff[t] <= '0;
            ctl_ff[t]   <= '0;
         end
         mask_ff    <= '0;
         flags_ff   <= '0;
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         res_cnt_ff <= '0;
      end else begin
         if (plain_we) begin
            plain_ff[op.reg_index] <= op.data;
         end
         latch_ff   <= latch_in;
         count_ff   <= count_in;
         ctl_ff     <= ctl_in;
         mask_ff    <= mask_in;
         flags_ff   <= flags_in;
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
         res_cnt_ff <= res_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (op_pop) begin
         res_ff[wr_ptr_ff] <= result;
      end
   end

   `CIATU_ASSERT(a_res_no_overrun, !(res_full && op_pop && !res_take))
   `CIATU_ASSERT(a_res_count_bound, res_cnt_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))
   `CIATU_ASSERT_NEXT(a_icr_read_clears, op_pop && op.kind == OP_READ && op.reg_class == RC_ICR, flags_ff == '0)
   `CIATU_ASSERT_NEXT(a_result_lands, op_pop && empty, !empty)

endmodule

### rtl/cia_timer_interrupt_unit_core.sv
// Top level of the CIA interval timer and interrupt unit.
//
//   channel   ports                          direction  transfer when
//   request   push, full, req_payload        in         push && !full
//   response  empty, pop, rsp_payload        out        pop && !empty
//
// One request per cycle sustained while the response side keeps popping;
// each request yields exactly one response. A request is written to the
// front op queue and executes at the edge the back end pops it, which needs
// room in the result queue or a response pop; its response is valid right
// after that edge, when it is written into the result queue.
// The execute step (timer subtract, underflow compare, reload add) is the
// critical path. Reset is synchronous; all timers, masks, flags and plain
// registers clear to zero. A stalled response side fills the two-entry
// result queue, then the two-entry op queue, after which full rises.
`include "cia_timer_interrupt_unit_core_defines.svh"
module cia_timer_interrupt_unit_core
   import ciatu_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   output logic            full,
   input  req_payload_type req_payload,
   output logic            empty,
   input  logic            pop,
   output rsp_payload_type rsp_payload
);

   logic   op_valid;
   logic   op_pop;
   op_type op;

   // decode and buffer requests
   ciatu_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_payload (req_payload),
      .op_valid    (op_valid),
      .op          (op),
      .op_pop      (op_pop)
   );

   // execute against register and timer state, queue responses
   ciatu_back u_back (
      .clock       (clock),
      .reset       (reset),
      .op_valid    (op_valid),
      .op          (op),
      .op_pop      (op_pop),
      .empty       (empty),
      .pop         (pop),
      .rsp_payload (rsp_payload)
   );

   // response transfers never exceed request transfers: with nothing queued
   // in front, the result side cannot grow
   `CIATU_ASSERT_NEXT(a_full_holds_off, full && !op_pop, full)
   `CIATU_ASSERT(a_pop_needs_op, !(op_pop && !op_valid))
   `CIATU_ASSERT_NEXT(a_fill_after_push, push && !full && !op_pop, op_valid)

endmodule
